FILE: rtl/mrs_pkg.sv
// types and constants for the midi running status parser
// used by mrs_state, mrs_decode and midi_running_status_parser; no dependencies
package mrs_pkg;

    // event codes on the result channel
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_REALTIME   = 4'd1,
        EV_SYSEX      = 4'd2,
        EV_NOTE       = 4'd3,
        EV_CONTROL    = 4'd4,
        EV_PROGRAM    = 4'd5,
        EV_BEND       = 4'd6,
        EV_CHAN_PRESS = 4'd7,
        EV_POLY_PRESS = 4'd8
    } event_kind_t;

    // status byte codes
    localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
    localparam logic [7:0] ST_NOTE_ON     = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS  = 8'hA0;
    localparam logic [7:0] ST_CONTROL     = 8'hB0;
    localparam logic [7:0] ST_PROGRAM     = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS  = 8'hD0;
    localparam logic [7:0] ST_BEND        = 8'hE0;
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_RESERVED_4  = 8'hF4;
    localparam logic [7:0] ST_RESERVED_5  = 8'hF5;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_REALTIME    = 8'hF8;
    localparam logic [7:0] ST_NONE        = 8'h00;

    // parser state held for one port
    typedef struct packed {
        logic [7:0] status;
        logic       have_first;
        logic [6:0] first_data;
    } port_state_t;

    // one result item
    typedef struct packed {
        logic [3:0]  out_port;
        logic        raw_valid;
        logic [7:0]  raw_value;
        event_kind_t event_kind;
        logic [3:0]  channel;
        logic [13:0] first_value;
        logic [6:0]  second_value;
        logic        dropped;
    } result_t;

endpackage

FILE: rtl/midi_running_status_parser.sv
// midi running status parser: input register, per-port state, decode, result register
// depends on mrs_pkg, mrs_state and mrs_decode
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  input   | in_valid / in_stall  | port, data_byte
//  result  | out_valid / out_stall| out_port, raw_valid, raw_value, event_kind,
//          |                      | channel, first_value, second_value, dropped
//
// one request per cycle unless stalled; results go via input then result register
// the port state is read and rewritten in the decode stage, so requests on
// the same port may follow one another without a gap
// reset clears the running status, pending byte and flag of every port at once
// a result stall holds result_reg and a full input register, raising in_stall
module midi_running_status_parser #(
    parameter int PORTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  port,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  out_port,
    output logic        raw_valid,
    output logic [7:0]  raw_value,
    output logic [3:0]  event_kind,
    output logic [3:0]  channel,
    output logic [13:0] first_value,
    output logic [6:0]  second_value,
    output logic        dropped
);

    // only sixteen ports can be addressed by the port field
    localparam int DEPTH = (PORTS < 16) ? PORTS : 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 in_valid_reg;
    logic [3:0]           port_reg;
    logic [7:0]           byte_reg;
    logic                 out_valid_reg;
    mrs_pkg::result_t     result_reg;
    mrs_pkg::result_t     result_next;
    mrs_pkg::port_state_t cur_state;
    mrs_pkg::port_state_t new_state;
    logic                 state_wr;
    logic                 in_range;
    logic                 out_free;
    logic                 advance;
    logic [IDX_W-1:0]     idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_range = 32'(port_reg) < PORTS;
    assign idx      = in_range ? port_reg[IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            port_reg <= port;
            byte_reg <= data_byte;
        end
    end

    mrs_state #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx),
        .rd_state (cur_state),
        .wr_en    (advance && state_wr),
        .wr_idx   (idx),
        .wr_state (new_state)
    );

    mrs_decode u_decode (
        .port      (port_reg),
        .data_byte (byte_reg),
        .in_range  (in_range),
        .cur_state (cur_state),
        .new_state (new_state),
        .state_wr  (state_wr),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_port     = result_reg.out_port;
    assign raw_valid    = result_reg.raw_valid;
    assign raw_value    = result_reg.raw_value;
    assign event_kind   = result_reg.event_kind;
    assign channel      = result_reg.channel;
    assign first_value  = result_reg.first_value;
    assign second_value = result_reg.second_value;
    assign dropped      = result_reg.dropped;

endmodule

FILE: rtl/mrs_state.sv
// per-port parser state: running status, pending first data byte and its flag
// depends on mrs_pkg
module mrs_state #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_idx,
    output mrs_pkg::port_state_t rd_state,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  mrs_pkg::port_state_t wr_state
);

    mrs_pkg::port_state_t state_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_idx];

endmodule

FILE: rtl/mrs_decode.sv
// decode of one byte against its port state: builds the result and the new state
// depends on mrs_pkg
module mrs_decode (
    input  logic [3:0]           port,
    input  logic [7:0]           data_byte,
    input  logic                 in_range,
    input  mrs_pkg::port_state_t cur_state,
    output mrs_pkg::port_state_t new_state,
    output logic                 state_wr,
    output mrs_pkg::result_t     result
);

    logic [7:0] rs;
    logic [7:0] stype;
    logic [3:0] ch;
    logic [6:0] lo7;
    logic       pair;

    assign rs    = cur_state.status;
    assign stype = (rs >= mrs_pkg::ST_SYSEX_START) ? rs : {rs[7:4], 4'h0};
    assign ch    = rs[3:0];
    assign lo7   = data_byte[6:0];
    assign pair  = cur_state.have_first;

    always_comb
    begin
        new_state = cur_state;
        state_wr  = in_range;
        result    = '0;
        result.out_port   = port;
        result.event_kind = mrs_pkg::EV_NONE;

        if (in_range)
        begin
            if (data_byte >= mrs_pkg::ST_REALTIME)
            begin
                result.event_kind  = mrs_pkg::EV_REALTIME;
                result.first_value = {6'd0, data_byte};
            end
            else if (data_byte[7])
            begin
                result.raw_valid     = 1'b1;
                result.raw_value     = data_byte;
                new_state.have_first = 1'b0;
                case (data_byte)
                    mrs_pkg::ST_RESERVED_4,
                    mrs_pkg::ST_RESERVED_5,
                    mrs_pkg::ST_TUNE_REQ:
                    begin
                        new_state.status = mrs_pkg::ST_NONE;
                    end
                    mrs_pkg::ST_SYSEX_START:
                    begin
                        result.event_kind  = mrs_pkg::EV_SYSEX;
                        result.first_value = {6'd0, data_byte};
                        new_state.status   = data_byte;
                    end
                    mrs_pkg::ST_SYSEX_END:
                    begin
                        result.event_kind  = mrs_pkg::EV_SYSEX;
                        result.first_value = {6'd0, data_byte};
                        new_state.status   = mrs_pkg::ST_NONE;
                    end
                    default:
                    begin
                        new_state.status = data_byte;
                    end
                endcase
            end
            else if (!rs[7])
            begin
                result.dropped = 1'b1;
            end
            else
            begin
                result.raw_valid = 1'b1;
                result.raw_value = data_byte;
                case (stype)
                    mrs_pkg::ST_NOTE_OFF,
                    mrs_pkg::ST_NOTE_ON,
                    mrs_pkg::ST_POLY_PRESS,
                    mrs_pkg::ST_CONTROL,
                    mrs_pkg::ST_BEND,
                    mrs_pkg::ST_SONG_POS:
                    begin
                        // two-byte messages: store the first, report on the second
                        if (pair)
                        begin
                            new_state.have_first = 1'b0;
                            if (stype != mrs_pkg::ST_SONG_POS)
                            begin
                                result.channel = ch;
                            end
                            case (stype)
                                mrs_pkg::ST_NOTE_OFF:
                                begin
                                    result.event_kind  = mrs_pkg::EV_NOTE;
                                    result.first_value = {7'd0, cur_state.first_data};
                                end
                                mrs_pkg::ST_NOTE_ON:
                                begin
                                    result.event_kind   = mrs_pkg::EV_NOTE;
                                    result.first_value  = {7'd0, cur_state.first_data};
                                    result.second_value = lo7;
                                end
                                mrs_pkg::ST_POLY_PRESS:
                                begin
                                    result.event_kind   = mrs_pkg::EV_POLY_PRESS;
                                    result.first_value  = {7'd0, cur_state.first_data};
                                    result.second_value = lo7;
                                end
                                mrs_pkg::ST_CONTROL:
                                begin
                                    result.event_kind   = mrs_pkg::EV_CONTROL;
                                    result.first_value  = {7'd0, cur_state.first_data};
                                    result.second_value = lo7;
                                end
                                mrs_pkg::ST_BEND:
                                begin
                                    // lsb arrives first, msb second
                                    result.event_kind  = mrs_pkg::EV_BEND;
                                    result.first_value = {lo7, cur_state.first_data};
                                end
                                default:
                                begin
                                    // song position complete
                                    new_state.status = mrs_pkg::ST_NONE;
                                end
                            endcase
                        end
                        else
                        begin
                            new_state.first_data = lo7;
                            new_state.have_first = 1'b1;
                        end
                    end
                    mrs_pkg::ST_PROGRAM:
                    begin
                        result.event_kind  = mrs_pkg::EV_PROGRAM;
                        result.channel     = ch;
                        result.first_value = {6'd0, data_byte};
                    end
                    mrs_pkg::ST_CHAN_PRESS:
                    begin
                        result.event_kind  = mrs_pkg::EV_CHAN_PRESS;
                        result.channel     = ch;
                        result.first_value = {6'd0, data_byte};
                    end
                    mrs_pkg::ST_SYSEX_START:
                    begin
                        result.event_kind  = mrs_pkg::EV_SYSEX;
                        result.first_value = {6'd0, data_byte};
                    end
                    mrs_pkg::ST_TIME_CODE,
                    mrs_pkg::ST_SONG_SEL:
                    begin
                        new_state.status = mrs_pkg::ST_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
